@@ rtl/kmc_pkg.sv @@
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the k-mer reference match counter.
// ----------------------------------------------------------------------------
`default_nettype none

package kmc_pkg;

    localparam int KMER_CHARS  = 32;
    localparam int CHAR_BITS   = 8;
    localparam int WORD_BITS   = 64;
    localparam int KMER_BITS   = KMER_CHARS * CHAR_BITS;

    localparam int INDEX_BITS  = 17;
    localparam int USED_BITS   = 18;
    localparam int COUNT_BITS  = 32;

    localparam logic [USED_BITS-1:0]  USED_RESET = 18'd131072;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;      // write entry, return load result
        logic query_cap;    // latch query, search limit, reset scan
        logic issue;        // issue one table read
        logic finish_hit;   // return found result, bump counter
        logic finish_miss;  // return not-found result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;          // registered read data equals query
        logic more;         // entries left to issue
        logic rd_busy;      // a read is in flight
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/kmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmc_ctrl
// Controller: accepts commands, sequences the table scan of a query.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_ctrl
    import kmc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       command,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_QUERY)
                    begin
                        cmd.query_cap = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (status.more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!status.rd_busy)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/kmc_datapath.sv @@
// ----------------------------------------------------------------------------
// kmc_datapath
// Reference table, scan counter, compare stage, hit counter and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_datapath
    import kmc_pkg::*;
#(
    parameter int TABLE_DEPTH = 131072
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire logic [INDEX_BITS-1:0] entry_index,
    input  wire logic [WORD_BITS-1:0]  chars_0,
    input  wire logic [WORD_BITS-1:0]  chars_1,
    input  wire logic [WORD_BITS-1:0]  chars_2,
    input  wire logic [WORD_BITS-1:0]  chars_3,
    input  wire logic                  cfg_wr,
    input  wire logic [USED_BITS-1:0]  cfg_data,
    output logic                       done,
    output logic                       found,
    output logic [INDEX_BITS-1:0]      match_index,
    output logic [COUNT_BITS-1:0]      hit_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

    logic [KMER_BITS-1:0] mem [TABLE_DEPTH];

    logic [KMER_BITS-1:0]  kmer_in;
    logic [KMER_BITS-1:0]  query_reg;
    logic [KMER_BITS-1:0]  rd_data_reg;
    logic [USED_BITS-1:0]  used_reg;
    logic [CW-1:0]         limit_reg;
    logic [CW-1:0]         limit_next;
    logic [CW-1:0]         issue_cnt_reg;
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic [INDEX_BITS-1:0] match_index_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;

    logic [31:0]           used32;
    logic [31:0]           limit32;
    logic [31:0]           widx32;
    logic                  wr_in_range;
    logic [31:0]           ridx32;

    assign kmer_in = {chars_3, chars_2, chars_1, chars_0};

    // search length clamps to the table depth
    assign used32     = {{(32-USED_BITS){1'b0}}, used_reg};
    assign limit32    = (used32 > DEPTH32) ? DEPTH32 : used32;
    assign limit_next = limit32[CW-1:0];

    assign widx32      = {{(32-INDEX_BITS){1'b0}}, entry_index};
    assign wr_in_range = (widx32 < DEPTH32);

    assign ridx32 = {{(32-AW){1'b0}}, rd_idx_reg};

    assign status.hit     = rd_valid_reg && (rd_data_reg == query_reg);
    assign status.more    = (issue_cnt_reg < limit_reg);
    assign status.rd_busy = rd_valid_reg;

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_in_range)
        begin
            mem[widx32[AW-1:0]] <= kmer_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[issue_cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_cap)
        begin
            query_reg <= kmer_in;
            limit_reg <= limit_next;
        end
        if (cmd.issue)
        begin
            rd_idx_reg <= issue_cnt_reg[AW-1:0];
        end
        if (cmd.load_wr || cmd.finish_miss)
        begin
            found_reg       <= 1'b0;
            match_index_reg <= '0;
        end
        else if (cmd.finish_hit)
        begin
            found_reg       <= 1'b1;
            match_index_reg <= ridx32[INDEX_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= USED_RESET;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            hit_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                used_reg <= cfg_data;
            end
            if (cmd.query_cap)
            begin
                issue_cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            rd_valid_reg <= cmd.issue;
            done_reg     <= cmd.load_wr || cmd.finish_hit || cmd.finish_miss;
            if (cmd.finish_hit && (hit_count_reg != COUNT_MAX))
            begin
                hit_count_reg <= hit_count_reg + 1'b1;
            end
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign hit_count   = hit_count_reg;

endmodule

`default_nettype wire

@@ rtl/kmer_reference_match_counter.sv @@
// ----------------------------------------------------------------------------
// kmer_reference_match_counter
// Exact-match search of a 32-character k-mer over a loaded reference table.
//
//  channel   signals                                   direction  handshake
//  command   start, busy, command, entry_index,        in         start & !busy
//            chars_0 .. chars_3
//  result    done, found, match_index, hit_count       out        done, 1 cycle
//  config    cfg_valid, cfg_ready, cfg_data            in         valid & ready
//
// A load never raises busy; done pulses the next cycle.
// A query holds busy until the scan ends, at the first entry j that matches or,
// on a miss, after all L entries, L = min(used_entries, TABLE_DEPTH): the single
// table read port scans one entry per cycle. done pulses in the first cycle
// with busy low again.
// Reset clears control, the hit counter and sets used_entries to 131072; the
// table is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_reference_match_counter
    import kmc_pkg::*;
#(
    parameter int TABLE_DEPTH = 131072
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  command,
    input  wire logic [INDEX_BITS-1:0] entry_index,
    input  wire logic [WORD_BITS-1:0]  chars_0,
    input  wire logic [WORD_BITS-1:0]  chars_1,
    input  wire logic [WORD_BITS-1:0]  chars_2,
    input  wire logic [WORD_BITS-1:0]  chars_3,
    output logic                       done,
    output logic                       found,
    output logic [INDEX_BITS-1:0]      match_index,
    output logic [COUNT_BITS-1:0]      hit_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [USED_BITS-1:0]  cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = !busy;

    kmc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    kmc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (entry_index),
        .chars_0     (chars_0),
        .chars_1     (chars_1),
        .chars_2     (chars_2),
        .chars_3     (chars_3),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .found       (found),
        .match_index (match_index),
        .hit_count   (hit_count)
    );

endmodule

`default_nettype wire

@@ rtl/kmc_checker.sv @@
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks on command acceptance, results and the hit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module kmc_checker
    import kmc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic                  command,
    input  wire logic                  done,
    input  wire logic                  found,
    input  wire logic [INDEX_BITS-1:0] match_index,
    input  wire logic [COUNT_BITS-1:0] hit_count
);

    // an accepted query always starts a scan
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_QUERY) |=> busy)
        else $error("accepted query did not raise busy");

    // a found result bumps the counter unless saturated
    a_hit_bump: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |->
            (hit_count == $past(hit_count) + 32'd1) ||
            (($past(hit_count) == COUNT_MAX) && (hit_count == COUNT_MAX)))
        else $error("hit counter did not advance on a found result");

    // the counter moves only with a found result
    a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && found) |-> hit_count == $past(hit_count))
        else $error("hit counter changed without a found result");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> match_index == '0)
        else $error("nonzero match index on a not-found result");

endmodule

bind kmer_reference_match_counter kmc_checker u_kmc_checker (.*);

`default_nettype wire
